// ----- hw/rtl/bdq_pkg.sv -----
// shared types and codes for the bounded deque with search
package bdq_pkg;

  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 7;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_DROP_BACK  = 2'd2,
    ACT_SEARCH     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  // report from the scan unit back to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

// ----- hw/rtl/bdq_mem.sv -----
// entry storage: one write port, one read port with registered data
module bdq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bdq_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [bdq_pkg::VALUE_W-1:0] rdata
);
  import bdq_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bdq_scan.sv -----
// scan unit: walks the ring from the front, one entry compare per cycle
module bdq_scan #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6,
  parameter int CW       = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [IW-1:0]               front,
  input  logic [CW-1:0]               count,
  input  logic [bdq_pkg::VALUE_W-1:0] key_in,
  output logic [IW-1:0]               raddr,
  input  logic [bdq_pkg::VALUE_W-1:0] rdata,
  output bdq_pkg::scan_rsp_t          rsp
);
  import bdq_pkg::*;

  logic               active;
  logic [IW-1:0]      addr;
  logic [CW-1:0]      left;
  logic [VALUE_W-1:0] key;
  logic               rd_valid;
  logic               rd_last;
  logic               hit;
  logic               match;
  logic [IW-1:0]      addr_inc;

  assign raddr    = addr;
  assign match    = rd_valid && (rdata == key);
  assign addr_inc = (addr == IW'(CAPACITY - 1)) ? '0 : addr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      if (go) begin
        active <= 1'b1;
      end else if (active && left == CW'(1)) begin
        active <= 1'b0;
      end
      rd_valid <= active;
      rd_last  <= active && left == CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      addr <= front;
      left <= count;
      key  <= key_in;
      hit  <= 1'b0;
    end else begin
      if (active) begin
        addr <= addr_inc;
        left <= left - 1'b1;
      end
      if (match) begin
        hit <= 1'b1;
      end
    end
  end

  // last compare is folded in directly
  assign rsp.done = rd_valid && rd_last;
  assign rsp.hit  = hit || match;

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> !active && !rd_valid)
    else $error("scan started while a scan is running");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !active)
    else $error("scan finished with reads still pending");

  a_last_once: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("scan reported done twice in a row");

endmodule

// ----- hw/rtl/bounded_deque_with_search.sv -----
// top level: ring-buffer deque of signed words with a sequential search
//
// Usage: drive action and value with start high; the beat is taken at a
// rising edge where start is high and busy is low. Every beat gives one
// result: done is high for exactly one cycle with status, found,
// entry_total and is_empty valid alongside it.
// Push front, push back and drop back complete at once: the result shows in
// the cycle after the beat, and busy stays low so a new beat may follow
// at once. A search walks the stored entries from the front through the
// entry memory's single read port, one entry per cycle; busy is high until
// the result shows. On an empty list a search gives its result in the
// cycle after the beat, like the other actions, and busy stays low.
// A full list refuses pushes and an empty one refuses drops with a status
// code; the state does not change. Reset empties the list; the memory
// itself is not cleared. The receiver cannot hold results off.
module bounded_deque_with_search #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [bdq_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output logic [1:0]                  status,
  output logic                        found,
  output logic [bdq_pkg::TOTAL_W-1:0] entry_total,
  output logic                        is_empty
);
  import bdq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  logic [IW-1:0]      front, front_next;
  logic [CW-1:0]      count, count_next;
  status_t            res_status, status_q;
  logic               accept;
  logic               full;
  logic               list_empty;
  logic [IW-1:0]      front_dec;
  logic [IW:0]        back_sum;
  logic [IW-1:0]      back_pos;
  logic               we;
  logic [IW-1:0]      waddr;
  logic               scan_go;
  logic [IW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;
  scan_rsp_t          rsp;

  assign accept     = start && !busy;
  assign full       = (count == CW'(CAPACITY));
  assign list_empty = (count == '0);
  assign front_dec  = (front == '0) ? IW'(CAPACITY - 1) : front - 1'b1;
  assign back_sum   = {1'b0, front} + (IW+1)'(count);
  // back slot wraps by one subtract since front stays below capacity and count at most reaches it
  assign back_pos   = (back_sum >= (IW+1)'(CAPACITY)) ?
                      IW'(back_sum - (IW+1)'(CAPACITY)) : back_sum[IW-1:0];

  always_comb begin
    front_next = front;
    count_next = count;
    we         = 1'b0;
    waddr      = back_pos;
    res_status = ST_DONE;
    scan_go    = 1'b0;
    if (accept) begin
      case (action_t'(action))
        ACT_PUSH_FRONT: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            we         = 1'b1;
            waddr      = front_dec;
            front_next = front_dec;
            count_next = count + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            we         = 1'b1;
            count_next = count + 1'b1;
          end
        end
        ACT_DROP_BACK: begin
          if (list_empty) begin
            res_status = ST_EMPTY;
          end else begin
            count_next = count - 1'b1;
          end
        end
        default: begin
          scan_go = !list_empty;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (scan_go) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (rsp.done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      S_SEARCH: busy = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= (accept && !scan_go) || (state == S_SEARCH && rsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q    <= res_status;
      found       <= 1'b0;
      entry_total <= TOTAL_W'(count_next);
      is_empty    <= (count_next == '0);
    end else if (state == S_SEARCH && rsp.done) begin
      status_q    <= ST_DONE;
      found       <= rsp.hit;
      entry_total <= TOTAL_W'(count);
      is_empty    <= 1'b0;
    end
  end

  assign status = status_q;

  bdq_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  bdq_scan #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .go     (scan_go),
    .front  (front),
    .count  (count),
    .key_in (value),
    .raddr  (raddr),
    .rdata  (rdata),
    .rsp    (rsp)
  );

  a_rsp_in_search: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_SEARCH)
    else $error("scan result outside a search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY) && (IW+1)'(front) < (IW+1)'(CAPACITY))
    else $error("ring pointers out of range");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    scan_go |=> busy && !done)
    else $error("search beat did not hold off new beats");

  a_no_write_search: assert property (@(posedge clk) disable iff (rst)
    busy |-> !we)
    else $error("memory written during a search");

endmodule

// ----- tb/testbench.sv -----
// testbench for the bounded deque with search: queued driver, predicting monitor
`timescale 1ns / 100ps

module testbench;
  import bdq_pkg::*;

  localparam int CAP         = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 700;

  typedef struct {
    action_t              act;
    logic [VALUE_W-1:0]   val;
    int                   gap;
  } request_t;

  typedef struct {
    status_t              status;
    logic                 found;
    logic [TOTAL_W-1:0]   total;
    logic                 empty;
  } outcome_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           action = '0;
  logic [VALUE_W-1:0]   value = '0;
  logic                 busy;
  logic                 done;
  logic [1:0]           status;
  logic                 found;
  logic [TOTAL_W-1:0]   entry_total;
  logic                 is_empty;

  request_t             req_q[$];
  outcome_t             outcome_q[$];
  logic                 taken = 1'b0;
  int                   wait_cnt = 0;
  int                   idle_cycles = 0;
  int                   fail_count = 0;

  // predictor state
  logic [VALUE_W-1:0]   deque_mem [CAP];
  logic [5:0]           deque_front;
  logic [TOTAL_W-1:0]   deque_count;

  // generator bookkeeping
  int                   gen_count = 0;
  logic [VALUE_W-1:0]   recent_vals[$];

  bounded_deque_with_search #(.CAPACITY(CAP)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .value       (value),
    .done        (done),
    .status      (status),
    .found       (found),
    .entry_total (entry_total),
    .is_empty    (is_empty)
  );

  always #2 clk = ~clk;

  task automatic deque_apply(input action_t a, input logic [VALUE_W-1:0] v,
                             output outcome_t o);
    logic [5:0] idx;
    int k;
    o.status = ST_DONE;
    o.found  = 1'b0;
    case (a)
      ACT_PUSH_FRONT: begin
        if (deque_count >= CAP) begin
          o.status = ST_FULL;
        end else begin
          deque_front = deque_front - 6'd1;
          deque_mem[deque_front] = v;
          deque_count = deque_count + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (deque_count >= CAP) begin
          o.status = ST_FULL;
        end else begin
          idx = deque_front + deque_count[5:0];
          deque_mem[idx] = v;
          deque_count = deque_count + 1'b1;
        end
      end
      ACT_DROP_BACK: begin
        if (deque_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          deque_count = deque_count - 1'b1;
        end
      end
      default: begin
        for (k = 0; k < deque_count; k++) begin
          idx = deque_front + k[5:0];
          if (deque_mem[idx] == v) o.found = 1'b1;
        end
      end
    endcase
    o.total = deque_count;
    o.empty = (deque_count == 0);
  endtask

  function automatic void queue_req(action_t a, logic [VALUE_W-1:0] v, int gap);
    request_t r;
    r.act = a;
    r.val = v;
    r.gap = gap;
    req_q.push_back(r);
    if ((a == ACT_PUSH_FRONT || a == ACT_PUSH_BACK) && gen_count < CAP) begin
      gen_count++;
      recent_vals.push_back(v);
      if (recent_vals.size() > 32) void'(recent_vals.pop_front());
    end else if (a == ACT_DROP_BACK && gen_count > 0) begin
      gen_count--;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(bit for_search);
    int r;
    r = $urandom_range(0, 99);
    if (for_search && r < 60 && recent_vals.size() > 0)
      return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    if (!for_search && r < 8 && recent_vals.size() > 0)
      return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    if (r < 72) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic int pick_gap(bit no_gap);
    int r;
    if (no_gap) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: next beat goes out at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      if (req_q.size() == 0) begin
        start <= 1'b0;
      end else if (wait_cnt < req_q[0].gap) begin
        start <= 1'b0;
        wait_cnt <= wait_cnt + 1;
      end else begin
        start <= 1'b1;
        action <= req_q[0].act;
        value <= req_q[0].val;
        wait_cnt <= 0;
        void'(req_q.pop_front());
      end
    end
  end

  // monitor: check results first, then predict the beat taken at this edge
  always @(posedge clk) begin
    outcome_t exp_o;
    outcome_t new_o;
    if (rst) begin
      taken <= 1'b0;
      deque_front = '0;
      deque_count = '0;
    end else begin
      taken <= start && !busy;
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (status !== exp_o.status) begin
            $error("status: expected %0d, got %0d", exp_o.status, status);
            fail_count++;
          end
          if (found !== exp_o.found) begin
            $error("found: expected %0d, got %0d", exp_o.found, found);
            fail_count++;
          end
          if (entry_total !== exp_o.total) begin
            $error("entry_total: expected %0d, got %0d", exp_o.total, entry_total);
            fail_count++;
          end
          if (is_empty !== exp_o.empty) begin
            $error("is_empty: expected %0d, got %0d", exp_o.empty, is_empty);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        deque_apply(action_t'(action), value, new_o);
        outcome_q.push_back(new_o);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    seg_kind_t kind;
    int        n_rand;
    int        seg_len;
    int        extra;
    int        r;
    bit        no_gap;
    bit        first_seg;
    action_t   a;

    // directed: empty cases, extreme values, one- and two-entry tail
    queue_req(ACT_SEARCH,     32'h0000_0000, 0);
    queue_req(ACT_DROP_BACK,  32'h1234_5678, 0);
    queue_req(ACT_PUSH_FRONT, 32'h7fff_ffff, 0);
    queue_req(ACT_PUSH_BACK,  32'h8000_0000, 1);
    queue_req(ACT_PUSH_FRONT, 32'h0000_0000, 0);
    queue_req(ACT_PUSH_BACK,  32'hffff_ffff, 0);
    queue_req(ACT_SEARCH,     32'h8000_0000, 0);
    queue_req(ACT_SEARCH,     32'h7fff_ffff, 2);
    queue_req(ACT_SEARCH,     32'h0000_0001, 0);
    queue_req(ACT_SEARCH,     32'hffff_ffff, 0);
    queue_req(ACT_DROP_BACK,  32'h0000_0000, 0);
    queue_req(ACT_SEARCH,     32'hffff_ffff, 0);
    queue_req(ACT_DROP_BACK,  32'hffff_ffff, 0);
    queue_req(ACT_DROP_BACK,  32'h0000_0000, 0);
    queue_req(ACT_SEARCH,     32'h0000_0000, 0);
    queue_req(ACT_PUSH_BACK,  32'h0000_0005, 0);
    queue_req(ACT_DROP_BACK,  32'h0000_0000, 0);
    queue_req(ACT_SEARCH,     32'h0000_0005, 0);
    queue_req(ACT_SEARCH,     32'h0000_0000, 0);
    queue_req(ACT_DROP_BACK,  32'h0000_0000, 0);
    queue_req(ACT_DROP_BACK,  32'h0000_0000, 3);
    queue_req(ACT_PUSH_BACK,  32'h5555_5555, 0);
    queue_req(ACT_SEARCH,     32'haaaa_aaaa, 0);
    queue_req(ACT_SEARCH,     32'h5555_5555, 0);
    queue_req(ACT_DROP_BACK,  32'haaaa_aaaa, 0);

    // random: fill to full and past, drain to empty and past, mixed noise
    n_rand = 0;
    first_seg = 1'b1;
    while (n_rand < RANDOM_ITEMS) begin
      if (first_seg) begin
        kind = SEG_FILL;
      end else begin
        r = $urandom_range(0, 9);
        kind = (r < 4) ? SEG_FILL : (r < 7) ? SEG_DRAIN : SEG_MIXED;
      end
      first_seg = 1'b0;
      no_gap = ($urandom_range(0, 3) == 0);
      extra = $urandom_range(1, 4);
      seg_len = $urandom_range(20, 60);
      while (1) begin
        if (kind == SEG_FILL) begin
          if (gen_count >= CAP && extra == 0) break;
          r = $urandom_range(0, 99);
          if (r < 80) begin
            a = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            if (gen_count >= CAP) extra--;
          end else if (r < 85) begin
            a = ACT_DROP_BACK;
          end else begin
            a = ACT_SEARCH;
          end
        end else if (kind == SEG_DRAIN) begin
          if (gen_count == 0 && extra == 0) break;
          r = $urandom_range(0, 99);
          if (r < 75) begin
            a = ACT_DROP_BACK;
            if (gen_count == 0) extra--;
          end else if (r < 82) begin
            a = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
          end else begin
            a = ACT_SEARCH;
          end
        end else begin
          if (seg_len == 0) break;
          seg_len--;
          a = action_t'($urandom_range(0, 3));
        end
        if (a == ACT_DROP_BACK)
          queue_req(a, $urandom, pick_gap(no_gap));
        else
          queue_req(a, pick_value(a == ACT_SEARCH), pick_gap(no_gap));
        n_rand++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
